[sv/bpt_pkg.sv]
package bpt_pkg;

	// Fixed field widths of the event and result beats.
	localparam int ACTION_W   = 3;
	localparam int ID_W       = 8;
	localparam int ERR_W      = 3;
	localparam int CNT_W      = 6;
	localparam int CNT_MAX    = 63;

	// Number of borrow slots examined per scan cycle.
	localparam int SCAN_LANES = 8;

	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 3'd0,
		ACT_SHARED = 3'd1,
		ACT_EXCL   = 3'd2,
		ACT_MOVE   = 3'd3,
		ACT_DROP   = 3'd4,
		ACT_END    = 3'd5,
		ACT_USE    = 3'd6
	} action_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_NONE     = 3'd0,
		ERR_MOVED    = 3'd1,
		ERR_FREED    = 3'd2,
		ERR_MIXED    = 3'd3,
		ERR_MULTI    = 3'd4,
		ERR_DANGLING = 3'd5,
		ERR_FULL     = 3'd6
	} err_t;

	// Requests from the sequencer to the borrow table.
	typedef struct packed {
		logic start;
		logic alloc;
		logic alloc_excl;
		logic end_borrow;
		logic clear_all;
	} tbl_cmd_t;

	// Scan results reported by the borrow table, counts already saturated.
	typedef struct packed {
		logic             scan_done;
		logic             full;
		logic [CNT_W-1:0] shared_cnt;
		logic [CNT_W-1:0] excl_cnt;
		logic [CNT_W-1:0] any_cnt;
	} tbl_stat_t;

endpackage

[sv/bpt_slot_table.sv]
module bpt_slot_table #(
	parameter int BORROW_SLOTS = 32,
	parameter int ID_BITS      = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bpt_pkg::tbl_cmd_t  cmd,
	input  logic [ID_BITS-1:0] key_id,
	input  logic [ID_BITS-1:0] new_holder,
	output bpt_pkg::tbl_stat_t stat
);
	import bpt_pkg::*;

	localparam int LANES  = SCAN_LANES;
	localparam int NCHUNK = (BORROW_SLOTS + LANES - 1) / LANES;
	localparam int PAD    = NCHUNK * LANES;
	localparam int FI_W   = $clog2(PAD);
	localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
	localparam int ACC_W  = $clog2(BORROW_SLOTS + 1);
	localparam int POP_W  = $clog2(LANES + 1);

	logic [BORROW_SLOTS-1:0] valid_q;
	logic [BORROW_SLOTS-1:0] excl_q;
	logic [ID_BITS-1:0]      holder_q [BORROW_SLOTS];
	logic [ID_BITS-1:0]      owner_q  [BORROW_SLOTS];

	logic [PAD-1:0]          sh_vec_q, ex_vec_q, free_vec_q;
	logic [BORROW_SLOTS-1:0] sh_match, ex_match, free_now;
	logic [CHK_W-1:0]        chk_q;
	logic [FI_W-1:0]         base_q, free_idx_q, lane_sel;
	logic                    run_q, done_q, found_q, lane_hit;
	logic [ACC_W-1:0]        sh_acc_q, ex_acc_q, any_acc_q;
	logic [POP_W-1:0]        sh_pop, ex_pop, any_pop;

	// Per-slot match against the value being examined, all slots in parallel.
	always_comb begin
		for (int i = 0; i < BORROW_SLOTS; i++) begin
			sh_match[i] = valid_q[i] && (owner_q[i] == key_id) && !excl_q[i];
			ex_match[i] = valid_q[i] && (owner_q[i] == key_id) && excl_q[i];
			free_now[i] = !valid_q[i];
		end
	end

	// Count and first-free search over the current group of lanes.
	always_comb begin
		sh_pop   = '0;
		ex_pop   = '0;
		any_pop  = '0;
		lane_hit = 1'b0;
		lane_sel = '0;
		for (int l = 0; l < LANES; l++) begin
			sh_pop  = sh_pop + POP_W'(sh_vec_q[l]);
			ex_pop  = ex_pop + POP_W'(ex_vec_q[l]);
			any_pop = any_pop + POP_W'(sh_vec_q[l] | ex_vec_q[l]);
			if (!lane_hit && free_vec_q[l]) begin
				lane_hit = 1'b1;
				lane_sel = FI_W'(l);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			chk_q   <= '0;
			base_q  <= '0;
		end else if (cmd.start) begin
			run_q   <= 1'b1;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			chk_q   <= '0;
			base_q  <= '0;
		end else if (run_q) begin
			if (lane_hit) begin
				found_q <= 1'b1;
			end
			base_q <= base_q + FI_W'(LANES);
			chk_q  <= chk_q + CHK_W'(1);
			if (chk_q == CHK_W'(NCHUNK - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			sh_vec_q   <= PAD'(sh_match);
			ex_vec_q   <= PAD'(ex_match);
			free_vec_q <= PAD'(free_now);
			sh_acc_q   <= '0;
			ex_acc_q   <= '0;
			any_acc_q  <= '0;
		end else if (run_q) begin
			sh_vec_q   <= sh_vec_q >> LANES;
			ex_vec_q   <= ex_vec_q >> LANES;
			free_vec_q <= free_vec_q >> LANES;
			sh_acc_q   <= sh_acc_q + ACC_W'(sh_pop);
			ex_acc_q   <= ex_acc_q + ACC_W'(ex_pop);
			any_acc_q  <= any_acc_q + ACC_W'(any_pop);
			if (!found_q && lane_hit) begin
				free_idx_q <= base_q + lane_sel;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.clear_all) begin
			valid_q <= '0;
		end else if (cmd.end_borrow) begin
			for (int i = 0; i < BORROW_SLOTS; i++) begin
				if (valid_q[i] && holder_q[i] == key_id) begin
					valid_q[i] <= 1'b0;
				end
			end
		end else if (cmd.alloc) begin
			for (int i = 0; i < BORROW_SLOTS; i++) begin
				if (FI_W'(i) == free_idx_q) begin
					valid_q[i] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			for (int i = 0; i < BORROW_SLOTS; i++) begin
				if (FI_W'(i) == free_idx_q) begin
					holder_q[i] <= new_holder;
					owner_q[i]  <= key_id;
					excl_q[i]   <= cmd.alloc_excl;
				end
			end
		end
	end

	always_comb begin
		stat.scan_done  = done_q;
		stat.full       = !found_q;
		stat.shared_cnt = (32'(sh_acc_q) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(sh_acc_q);
		stat.excl_cnt   = (32'(ex_acc_q) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(ex_acc_q);
		stat.any_cnt    = (32'(any_acc_q) > 32'(CNT_MAX)) ? CNT_W'(CNT_MAX) : CNT_W'(any_acc_q);
	end

	// A slot is only claimed after a finished scan that found one free.
	a_alloc_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> (found_q && done_q))
		else $error("slot allocated without a free slot");

	// The sequencer never issues two table operations at once.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.start, cmd.alloc, cmd.end_borrow, cmd.clear_all}))
		else $error("overlapping borrow table operations");

endmodule

[sv/borrow_permission_tracker.sv]
// Borrow permission tracker.
// Each beat on the item channel (item_valid / item_stall) carries one ownership
// event: action, value_id and borrower_id. Each event produces exactly one beat on
// the result channel (result_valid / result_stall) with error_code, also_freed and
// conflict_count. Items are processed one at a time.
// Timing: after an item is accepted the moved/dropped flags are read from the flag
// memory in the READ state and, for clear, end borrow, use and unknown actions, the
// result is resolved in the cycle after that. Borrow, move and drop also scan the
// borrow table eight slots per cycle in the SCAN state before the resolve cycle.
// The result beat appears in the cycle after the resolve cycle.
// Reset and the begin-function action both start a clearing pass over the flag
// memory, one entry per cycle, during which item_stall is high. The borrow table
// is cleared at once.
// When the receiver stalls, the finished result waits in the output register. The
// block still accepts the next item and works on it, then holds that result in its
// resolve cycle, with no state written, until the output register is free.
module borrow_permission_tracker #(
	parameter int VALUE_COUNT  = 256,
	parameter int BORROW_SLOTS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [bpt_pkg::ACTION_W-1:0] action,
	input  logic [bpt_pkg::ID_W-1:0]     value_id,
	input  logic [bpt_pkg::ID_W-1:0]     borrower_id,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [bpt_pkg::ERR_W-1:0]    error_code,
	output logic                         also_freed,
	output logic [bpt_pkg::CNT_W-1:0]    conflict_count
);
	import bpt_pkg::*;

	localparam int IDX_W        = $clog2(VALUE_COUNT);
	localparam int ID_SPACE     = 1 << ID_W;
	localparam int FLAG_MOVED   = 0;
	localparam int FLAG_DROPPED = 1;

	typedef enum logic [4:0] {
		ST_CLEAR   = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_READ    = 5'b00100,
		ST_SCAN    = 5'b01000,
		ST_RESOLVE = 5'b10000
	} state_t;

	state_t            state_q;
	action_t           act_in, act_q;
	logic [IDX_W-1:0]  id_map [ID_SPACE];
	logic [IDX_W-1:0]  id_in, holder_in, id_q, holder_q, sweep_q;
	logic              scan_q, scan_in, accept, fire;

	// Flag memory: bit 0 moved, bit 1 dropped.
	logic [1:0]        flag_mem [VALUE_COUNT];
	logic [1:0]        rd_flags_q, mem_wdata, new_flags;
	logic [IDX_W-1:0]  mem_addr;
	logic              mem_we, upd;

	tbl_cmd_t          tcmd;
	tbl_stat_t         tstat;
	logic [IDX_W-1:0]  key_id;

	err_t              err;
	logic              freed;
	logic [CNT_W-1:0]  cnt;
	logic              do_alloc, do_end, do_clr;

	logic              result_valid_q;
	logic [ERR_W-1:0]  err_q;
	logic              freed_q;
	logic [CNT_W-1:0]  cnt_q;

	// Ids are taken modulo VALUE_COUNT; the map is a constant table.
	for (genvar g = 0; g < ID_SPACE; g++) begin : g_map
		assign id_map[g] = IDX_W'(g % VALUE_COUNT);
	end

	assign id_in      = id_map[value_id];
	assign holder_in  = id_map[borrower_id];
	assign act_in     = action_t'(action);
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign scan_in    = act_in inside {ACT_SHARED, ACT_EXCL, ACT_MOVE, ACT_DROP};
	assign fire       = (state_q == ST_RESOLVE) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + IDX_W'(1);
					if (sweep_q == IDX_W'(VALUE_COUNT - 1)) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= scan_q ? ST_SCAN : ST_RESOLVE;
				end
				ST_SCAN: begin
					if (tstat.scan_done) begin
						state_q <= ST_RESOLVE;
					end
				end
				ST_RESOLVE: begin
					if (fire) begin
						state_q <= (act_q == ACT_CLEAR) ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= act_in;
			id_q     <= id_in;
			holder_q <= holder_in;
			scan_q   <= scan_in;
		end
	end

	// The flag memory is written in the clearing pass or when a move or drop
	// succeeds. Its read is issued on acceptance, so the previous write has
	// always landed before the next read.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_addr  = sweep_q;
			mem_wdata = 2'b00;
		end else begin
			mem_we    = fire && upd;
			mem_addr  = id_q;
			mem_wdata = new_flags;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flag_mem[mem_addr] <= mem_wdata;
		end
		if (accept) begin
			rd_flags_q <= flag_mem[id_in];
		end
	end

	// Decide the outcome of the event from the flags and the scan counts.
	always_comb begin
		err       = ERR_NONE;
		freed     = 1'b0;
		cnt       = '0;
		upd       = 1'b0;
		new_flags = rd_flags_q;
		do_alloc  = 1'b0;
		do_end    = 1'b0;
		do_clr    = 1'b0;
		case (act_q)
			ACT_CLEAR: begin
				do_clr = 1'b1;
			end
			ACT_SHARED, ACT_EXCL: begin
				if (rd_flags_q[FLAG_MOVED]) begin
					err = ERR_MOVED;
				end else if (rd_flags_q[FLAG_DROPPED]) begin
					err = ERR_FREED;
				end else if (act_q == ACT_EXCL && tstat.shared_cnt != '0) begin
					err = ERR_MIXED;
					cnt = tstat.shared_cnt;
				end else if (tstat.excl_cnt != '0) begin
					err = (act_q == ACT_EXCL) ? ERR_MULTI : ERR_MIXED;
					cnt = tstat.excl_cnt;
				end else if (tstat.full) begin
					err = ERR_FULL;
				end else begin
					do_alloc = 1'b1;
				end
			end
			ACT_MOVE: begin
				if (rd_flags_q[FLAG_MOVED]) begin
					err = ERR_MOVED;
				end else if (rd_flags_q[FLAG_DROPPED]) begin
					err = ERR_FREED;
				end else if (tstat.any_cnt != '0) begin
					err = ERR_MOVED;
					cnt = tstat.any_cnt;
				end else begin
					upd                   = 1'b1;
					new_flags[FLAG_MOVED] = 1'b1;
				end
			end
			ACT_DROP: begin
				if (rd_flags_q[FLAG_DROPPED]) begin
					err = ERR_FREED;
				end else if (!rd_flags_q[FLAG_MOVED] && tstat.any_cnt != '0) begin
					err = ERR_DANGLING;
					cnt = tstat.any_cnt;
				end else begin
					upd                     = 1'b1;
					new_flags[FLAG_DROPPED] = 1'b1;
				end
			end
			ACT_END: begin
				do_end = 1'b1;
			end
			ACT_USE: begin
				if (rd_flags_q[FLAG_MOVED]) begin
					err   = ERR_MOVED;
					freed = rd_flags_q[FLAG_DROPPED];
				end else if (rd_flags_q[FLAG_DROPPED]) begin
					err = ERR_FREED;
				end
			end
			default: begin
			end
		endcase
	end

	assign key_id           = (state_q == ST_IDLE) ? id_in : id_q;
	assign tcmd.start       = accept && scan_in;
	assign tcmd.alloc       = fire && do_alloc;
	assign tcmd.alloc_excl  = (act_q == ACT_EXCL);
	assign tcmd.end_borrow  = fire && do_end;
	assign tcmd.clear_all   = fire && do_clr;

	bpt_slot_table #(
		.BORROW_SLOTS(BORROW_SLOTS),
		.ID_BITS     (IDX_W)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (tcmd),
		.key_id    (key_id),
		.new_holder(holder_q),
		.stat      (tstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			err_q   <= err;
			freed_q <= freed;
			cnt_q   <= cnt;
		end
	end

	assign result_valid   = result_valid_q;
	assign error_code     = err_q;
	assign also_freed     = freed_q;
	assign conflict_count = cnt_q;

	// The extra use-after-free mark only rides on a use-after-move result.
	a_freed_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && also_freed |-> error_code == ERR_MOVED)
		else $error("also_freed without use-after-move code");

	// A begin-function result is always followed by the clearing pass.
	a_clear_pass: assert property (@(posedge clk) disable iff (!arst_n)
		fire && act_q == ACT_CLEAR |=> state_q == ST_CLEAR)
		else $error("begin function did not start the clearing pass");

	// A new result beat comes only from the resolve cycle.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == ST_RESOLVE))
		else $error("result beat raised outside resolve");

	// The flag memory is never written while waiting for an item.
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mem_we)
		else $error("flag memory written while idle");

endmodule
